/* src/nearest_palette_color_search_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color search block
// Clocked implication helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define NPCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcs assertion failed");

// next-cycle implication
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcs assertion failed");

`endif

/* src/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants, types and helpers of the nearest palette color search.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

    localparam int ENTRY_IDX_W = 8;
    localparam int LEVEL_W     = 8;
    localparam int PIXEL_W     = 32;
    localparam int DIST_W      = LEVEL_W + 2;
    localparam int ENTRY_W     = 3 * LEVEL_W + PIXEL_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [DIST_W-1:0]  t_dist;

    typedef struct packed {
        t_level                red;
        t_level                green;
        t_level                blue;
        logic [PIXEL_W-1:0]    pixel;
    } t_entry;

    function automatic t_dist abs_diff(input t_level a, input t_level b);
        t_level d;
        d = (a > b) ? (a - b) : (b - a);
        return DIST_W'(d);
    endfunction

endpackage

/* src/nearest_palette_color_search_top.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette store with a sequential nearest color (sum of absolute differences)
// search over one shared distance unit.
// ----------------------------------------------------------------------------
// A write request stores one palette entry. A query request walks the
// palette one entry per cycle through a single distance and compare unit
// fed by the palette memory's registered read port: it ends after the last
// entry when no entry matches exactly, and at entry k when entry k is the
// first exact match. The input side is busy for the whole walk; a new
// request may be taken while a finished result still waits on the output.
// Entries never written read as zero through a per-entry valid bit, so
// reset needs no clearing pass.
module nearest_palette_color_search_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_operation,
    input  logic [npcs_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [npcs_pkg::LEVEL_W-1:0]     i_red_level,
    input  logic [npcs_pkg::LEVEL_W-1:0]     i_green_level,
    input  logic [npcs_pkg::LEVEL_W-1:0]     i_blue_level,
    input  logic [npcs_pkg::PIXEL_W-1:0]     i_device_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [npcs_pkg::PIXEL_W-1:0]     o_nearest_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                              r_state, n_state;
    logic [npcs_pkg::CNT_W-1:0]          r_rd_cnt, n_rd_cnt;
    logic                                r_cmp_vld, n_cmp_vld;
    logic                                r_cmp_last, n_cmp_last;
    npcs_pkg::t_dist                     r_best_dist, n_best_dist;
    logic [npcs_pkg::PIXEL_W-1:0]        r_best_pixel, n_best_pixel;
    logic                                r_out_valid, n_out_valid;
    logic [npcs_pkg::PIXEL_W-1:0]        r_out_pixel, n_out_pixel;
    logic [npcs_pkg::PALETTE_ENTRIES-1:0] r_valid, n_valid;
    npcs_pkg::t_level                    r_q_red, r_q_green, r_q_blue;

    npcs_pkg::t_entry                    r_mem [npcs_pkg::PALETTE_ENTRIES];
    npcs_pkg::t_entry                    r_rd_data;
    logic                                r_rd_hit;

    logic                                s_accept;
    logic                                s_wr_en;
    logic                                s_issue;
    logic [npcs_pkg::IDX_W-1:0]          s_wr_addr;
    logic [npcs_pkg::IDX_W-1:0]          s_rd_addr;
    npcs_pkg::t_entry                    s_entry;
    npcs_pkg::t_dist                     s_dist;

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_nearest_pixel = r_out_pixel;

    assign s_accept  = i_in_valid && o_in_ready;
    assign s_wr_en   = s_accept && (i_operation == npcs_pkg::OP_WRITE)
                       && (32'(i_entry_index) < 32'(npcs_pkg::PALETTE_ENTRIES));
    assign s_wr_addr = npcs_pkg::IDX_W'(i_entry_index);
    assign s_issue   = (r_state == ST_SCAN)
                       && (r_rd_cnt < npcs_pkg::CNT_W'(npcs_pkg::PALETTE_ENTRIES));
    assign s_rd_addr = r_rd_cnt[npcs_pkg::IDX_W-1:0];

    // palette memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[s_wr_addr] <= '{red:   i_red_level,
                                  green: i_green_level,
                                  blue:  i_blue_level,
                                  pixel: i_device_pixel};
        end
        r_rd_data <= r_mem[s_rd_addr];
        r_rd_hit  <= r_valid[s_rd_addr];
    end

    // query color
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_q_red   <= i_red_level;
            r_q_green <= i_green_level;
            r_q_blue  <= i_blue_level;
        end
    end

    // shared distance unit
    always_comb begin
        s_entry = r_rd_hit ? r_rd_data : '0;
        s_dist  = npcs_pkg::abs_diff(s_entry.red, r_q_red)
                + npcs_pkg::abs_diff(s_entry.green, r_q_green)
                + npcs_pkg::abs_diff(s_entry.blue, r_q_blue);
    end

    always_comb begin
        n_state      = r_state;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_last   = r_cmp_last;
        n_best_dist  = r_best_dist;
        n_best_pixel = r_best_pixel;
        n_out_valid  = r_out_valid;
        n_out_pixel  = r_out_pixel;
        n_valid      = r_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (s_wr_en) begin
            n_valid[s_wr_addr] = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && (i_operation == npcs_pkg::OP_QUERY)) begin
                    n_state     = ST_SCAN;
                    n_rd_cnt    = '0;
                    n_best_dist = '1;
                    n_cmp_last  = 1'b0;
                end
            end
            ST_SCAN: begin
                if (s_issue) begin
                    n_rd_cnt   = r_rd_cnt + npcs_pkg::CNT_W'(1);
                    n_cmp_vld  = 1'b1;
                    n_cmp_last = (r_rd_cnt == npcs_pkg::CNT_W'(npcs_pkg::PALETTE_ENTRIES - 1));
                end
                if (r_cmp_vld) begin
                    if (s_dist < r_best_dist) begin
                        n_best_dist  = s_dist;
                        n_best_pixel = s_entry.pixel;
                    end
                    if ((s_dist == '0) || r_cmp_last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = r_best_pixel;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_cnt    <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_best_dist <= '1;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_cnt    <= n_rd_cnt;
            r_cmp_vld   <= n_cmp_vld;
            r_cmp_last  <= n_cmp_last;
            r_best_dist <= n_best_dist;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_pixel <= n_best_pixel;
        r_out_pixel  <= n_out_pixel;
    end

endmodule

/* src/npcs_chk.sv */
// ----------------------------------------------------------------------------
// npcs_chk
// Port-level checks of the nearest palette color search, bound to the top.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_search_top_assert.svh"

module npcs_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             i_operation,
    input logic [npcs_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input logic [npcs_pkg::LEVEL_W-1:0]     i_red_level,
    input logic [npcs_pkg::LEVEL_W-1:0]     i_green_level,
    input logic [npcs_pkg::LEVEL_W-1:0]     i_blue_level,
    input logic [npcs_pkg::PIXEL_W-1:0]     i_device_pixel,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [npcs_pkg::PIXEL_W-1:0]     o_nearest_pixel
);

    logic s_query_acc;
    logic s_write_acc;

    assign s_query_acc = i_in_valid && o_in_ready && (i_operation == npcs_pkg::OP_QUERY);
    assign s_write_acc = i_in_valid && o_in_ready && (i_operation == npcs_pkg::OP_WRITE);

    `NPCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `NPCS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_nearest_pixel))
    `NPCS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, s_query_acc, !o_in_ready)
    `NPCS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, s_write_acc && !o_out_valid, !o_out_valid)

endmodule

bind nearest_palette_color_search_top npcs_chk u_npcs_chk (.*);
